// ----- hw/rtl/bmma_pkg.sv -----
// Shared definitions for the burst median and moving-average filter.
// Holds the register map, reset values and the sequencer state type.
// Depends on nothing; imported by the top level.
package bmma_pkg;

    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

    localparam logic [CFG_W-1:0] BURST_LENGTH_RST  = 5'd5;
    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 5'd10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAND,
        S_CLOAD,
        S_SCAN,
        S_CHECK,
        S_WWRITE,
        S_WRD0,
        S_WACC,
        S_DIVGO,
        S_DIVWAIT,
        S_OUT
    } state_t;

endpackage

// ----- hw/rtl/bmma_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Self-contained; instantiated by the filter top level for the window mean.
module bmma_div
#(
    parameter int NUM_W = 16,
    parameter int DEN_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = CNT_W'(NUM_W);
            rem_next  = '0;
            quot_next = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits DEN_W bits.
            rem_next  = fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            quot_next = {quot_reg[NUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- hw/rtl/burst_median_moving_average_top.sv -----
// Burst median followed by a moving average over the medians.
// Depends on bmma_pkg and the bmma_div divider.
//
// Samples arrive on the in_valid/in_ready channel, one per beat. Every
// burst_length beats the block takes the median (upper median for an even
// count) of the burst, writes it into a circular window and emits one beat
// on out_valid/out_ready carrying the truncated mean of the window in use
// and the median itself. Lengths are written on the cfg port while idle
// by the user; the block does not enforce it. Zero acts as one and
// values above the maximum act as the maximum. A sample that does not
// close a burst is written to the burst memory and in_ready stays high.
// A closing sample starts a rank search over the burst memory: each
// candidate is compared with every entry through one read port, one entry
// per cycle, at most n candidates; then the window is summed at one entry
// per cycle and the sum is divided by the number of entries in use.
// in_ready is low from the closing sample until the result is loaded into
// the output register; a stalled receiver only holds the next closing
// sample, never the samples in between. Reset clears the burst counter, the
// window position and all window valid bits, so the window reads as zero.
module burst_median_moving_average_top
    import bmma_pkg::*;
#(
    parameter int MAX_BURST   = 16,
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] average,
    output logic [SAMPLE_BITS-1:0] burst_median,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int BA_W  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
    localparam int BC_W  = $clog2(MAX_BURST + 1);
    localparam int WA_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WC_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       burst_length_reg, window_length_reg;
    logic [BC_W-1:0]        burst_count_reg, burst_count_next;
    logic [BA_W-1:0]        cand_idx_reg, cand_idx_next;
    logic [BA_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [SAMPLE_BITS-1:0] cand_reg, cand_next;
    logic [BC_W-1:0]        lt_reg, lt_next;
    logic [BC_W-1:0]        le_reg, le_next;
    logic [SAMPLE_BITS-1:0] median_reg, median_next;
    logic [WA_W-1:0]        wpos_reg, wpos_next;
    logic                   wrapped_reg, wrapped_next;
    logic [MAX_WINDOW-1:0]  wvalid_reg;
    logic [WC_W-1:0]        cnt_reg, cnt_next;
    logic [WA_W-1:0]        sum_idx_reg, sum_idx_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] average_reg, burst_median_reg;

    logic [SAMPLE_BITS-1:0] bmem [MAX_BURST];
    logic [SAMPLE_BITS-1:0] bmem_rdata_reg;
    logic [BA_W-1:0]        bmem_raddr;
    logic                   bmem_we;

    logic [SAMPLE_BITS-1:0] wmem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] wmem_rdata_reg;
    logic                   wvld_rd_reg;
    logic [WA_W-1:0]        wmem_raddr;
    logic                   wmem_we;

    logic [BC_W-1:0]        blen, half;
    logic [WC_W-1:0]        wlen;
    logic [BC_W-1:0]        count_inc;
    logic                   burst_done;
    logic                   found;
    logic [WC_W-1:0]        pos_inc;
    logic                   last_sum;
    logic                   out_free;
    logic                   in_accept;
    logic                   div_start, div_done;
    logic [SUM_W-1:0]       div_quot;
    logic [SAMPLE_BITS-1:0] wterm;

    always_comb
    begin
        if (burst_length_reg == '0)
            blen = BC_W'(1);
        else if (int'(burst_length_reg) > MAX_BURST)
            blen = BC_W'(MAX_BURST);
        else
            blen = BC_W'(burst_length_reg);
    end

    always_comb
    begin
        if (window_length_reg == '0)
            wlen = WC_W'(1);
        else if (int'(window_length_reg) > MAX_WINDOW)
            wlen = WC_W'(MAX_WINDOW);
        else
            wlen = WC_W'(window_length_reg);
    end

    assign half       = blen >> 1;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign count_inc  = burst_count_reg + 1'b1;
    assign burst_done = count_inc >= blen;
    // The candidate is the median when its rank range covers index n/2.
    assign found      = (lt_reg <= half) && (half < le_reg);
    assign pos_inc    = WC_W'(wpos_reg) + 1'b1;
    assign last_sum   = WC_W'(sum_idx_reg) == (cnt_reg - 1'b1);
    assign out_free   = !out_valid_reg || out_ready;
    assign wterm      = wvld_rd_reg ? wmem_rdata_reg : '0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_accept && burst_done)
                    state_next = S_CAND;
            S_CAND:
                state_next = S_CLOAD;
            S_CLOAD:
                state_next = S_SCAN;
            S_SCAN:
                if (BC_W'(scan_idx_reg) == blen - 1'b1)
                    state_next = S_CHECK;
            S_CHECK:
                state_next = found ? S_WWRITE : S_CAND;
            S_WWRITE:
                state_next = S_WRD0;
            S_WRD0:
                state_next = S_WACC;
            S_WACC:
                if (last_sum)
                    state_next = S_DIVGO;
            S_DIVGO:
                state_next = S_DIVWAIT;
            S_DIVWAIT:
                if (div_done)
                    state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        burst_count_next = burst_count_reg;
        cand_idx_next    = cand_idx_reg;
        scan_idx_next    = scan_idx_reg;
        cand_next        = cand_reg;
        lt_next          = lt_reg;
        le_next          = le_reg;
        median_next      = median_reg;
        wpos_next        = wpos_reg;
        wrapped_next     = wrapped_reg;
        cnt_next         = cnt_reg;
        sum_idx_next     = sum_idx_reg;
        sum_next         = sum_reg;
        bmem_we          = 1'b0;
        bmem_raddr       = cand_idx_reg;
        wmem_we          = 1'b0;
        wmem_raddr       = '0;
        div_start        = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
                if (in_accept)
                begin
                    bmem_we = 1'b1;
                    if (burst_done)
                    begin
                        burst_count_next = '0;
                        cand_idx_next    = '0;
                    end
                    else
                        burst_count_next = count_inc;
                end
            S_CAND:
                bmem_raddr = cand_idx_reg;
            S_CLOAD:
            begin
                cand_next     = bmem_rdata_reg;
                bmem_raddr    = '0;
                scan_idx_next = '0;
                lt_next       = '0;
                le_next       = '0;
            end
            S_SCAN:
            begin
                bmem_raddr    = BA_W'(scan_idx_reg + 1'b1);
                scan_idx_next = BA_W'(scan_idx_reg + 1'b1);
                if (bmem_rdata_reg < cand_reg)
                    lt_next = lt_reg + 1'b1;
                if (bmem_rdata_reg <= cand_reg)
                    le_next = le_reg + 1'b1;
            end
            S_CHECK:
                if (found)
                    median_next = cand_reg;
                else
                    cand_idx_next = BA_W'(cand_idx_reg + 1'b1);
            S_WWRITE:
            begin
                wmem_we = 1'b1;
                if (pos_inc >= wlen)
                begin
                    wpos_next    = '0;
                    wrapped_next = 1'b1;
                    cnt_next     = wlen;
                end
                else
                begin
                    wpos_next = pos_inc[WA_W-1:0];
                    cnt_next  = wrapped_reg ? wlen : pos_inc;
                end
            end
            S_WRD0:
            begin
                wmem_raddr   = '0;
                sum_idx_next = '0;
                sum_next     = '0;
            end
            S_WACC:
            begin
                wmem_raddr   = WA_W'(sum_idx_reg + 1'b1);
                sum_idx_next = WA_W'(sum_idx_reg + 1'b1);
                sum_next     = sum_reg + SUM_W'(wterm);
            end
            S_DIVGO:
                div_start = 1'b1;
            S_DIVWAIT:
                div_start = 1'b0;
            S_OUT:
                if (out_free)
                    out_valid_next = 1'b1;
            default:
                div_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            burst_length_reg  <= BURST_LENGTH_RST;
            window_length_reg <= WINDOW_LENGTH_RST;
            burst_count_reg   <= '0;
            wpos_reg          <= '0;
            wrapped_reg       <= 1'b0;
            wvalid_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            burst_count_reg <= burst_count_next;
            wpos_reg        <= wpos_next;
            wrapped_reg     <= wrapped_next;
            out_valid_reg   <= out_valid_next;
            if (wmem_we)
                wvalid_reg[wpos_reg] <= 1'b1;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BURST_LENGTH:  burst_length_reg  <= cfg_data;
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                    default:           burst_length_reg  <= burst_length_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_idx_reg <= cand_idx_next;
        scan_idx_reg <= scan_idx_next;
        cand_reg     <= cand_next;
        lt_reg       <= lt_next;
        le_reg       <= le_next;
        median_reg   <= median_next;
        cnt_reg      <= cnt_next;
        sum_idx_reg  <= sum_idx_next;
        sum_reg      <= sum_next;
        if (state_reg == S_OUT && out_free)
        begin
            average_reg      <= div_quot[SAMPLE_BITS-1:0];
            burst_median_reg <= median_reg;
        end
    end

    // Burst sample memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (bmem_we)
            bmem[burst_count_reg[BA_W-1:0]] <= sample;
        bmem_rdata_reg <= bmem[bmem_raddr];
    end

    // Window memory; an entry never written reads as zero through its valid bit.
    always_ff @(posedge clk)
    begin
        if (wmem_we)
            wmem[wpos_reg] <= median_reg;
        wmem_rdata_reg <= wmem[wmem_raddr];
        wvld_rd_reg    <= wvalid_reg[wmem_raddr];
    end

    bmma_div #(
        .NUM_W (SUM_W),
        .DEN_W (WC_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (cnt_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid    = out_valid_reg;
    assign average      = average_reg;
    assign burst_median = burst_median_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(burst_count_reg) < MAX_BURST)
        else $error("burst count reached the burst memory depth");

    a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CAND |-> BC_W'(cand_idx_reg) < blen)
        else $error("median search ran past the end of the burst");

    a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRD0 |-> WC_W'(wpos_reg) < wlen)
        else $error("window position left outside the window");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVWAIT)
        else $error("divider finished while the sequencer was not waiting");

endmodule
